/* src/trle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the run-length coded pixel decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 32;
    localparam int PPL_W    = 8;
    localparam int CFG_IDX_W = 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL = 1'd1;

    localparam logic [BYTE_W-1:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] HDR_RUN_MASK   = 8'h80;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE   = 8'hff;

    localparam int RES_DATA_W = 5 * BYTE_W;

    typedef struct packed {
        logic              overrun;
        logic              last_pixel;
        logic [BYTE_W-1:0] repeat_res;
        logic [BYTE_W-1:0] alpha;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } t_pixel_res;

endpackage

/* src/trle_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_core
// Packet state, pixel assembly and image counting; one byte per advance.
// ----------------------------------------------------------------------------
module trle_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [trle_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_cfg_we,
    input  logic [trle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [trle_pkg::COUNT_W-1:0]  i_cfg_data,
    output logic                          o_res_valid,
    output trle_pkg::t_pixel_res          o_res
);
    import trle_pkg::*;

    logic               r_four_byte;
    logic [COUNT_W-1:0] r_pixel_total;

    logic               r_in_body, n_in_body;
    logic               r_run, n_run;
    logic [PPL_W-1:0]   r_ppl, n_ppl;
    logic [1:0]         r_bpos, n_bpos;
    logic [23:0]        r_partial, n_partial;
    logic [COUNT_W-1:0] r_ipl, n_ipl;
    logic               r_discard, n_discard;

    logic [1:0]         lastpos;
    logic [COUNT_W-1:0] ppl_wide;
    logic [PPL_W-1:0]   ppl_dec;
    logic [COUNT_W-1:0] ipl_dec;
    logic [PPL_W-1:0]   run_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_byte   <= 1'b1;
            r_pixel_total <= COUNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOUR_BYTE:   r_four_byte   <= i_cfg_data[0];
                CFG_PIXEL_TOTAL: r_pixel_total <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign lastpos  = r_four_byte ? 2'd3 : 2'd2;
    assign ppl_wide = {{(COUNT_W-PPL_W){1'b0}}, r_ppl};
    assign ppl_dec  = (r_ppl != '0) ? r_ppl - 1'b1 : r_ppl;
    assign ipl_dec  = (r_ipl != '0) ? r_ipl - 1'b1 : r_ipl;
    assign run_rep  = (ppl_wide < r_ipl) ? r_ppl : r_ipl[PPL_W-1:0];

    always_comb begin
        n_in_body  = r_in_body;
        n_run      = r_run;
        n_ppl      = r_ppl;
        n_bpos     = r_bpos;
        n_partial  = r_partial;
        n_ipl      = r_ipl;
        n_discard  = r_discard;
        o_res_valid = 1'b0;
        o_res.blue  = r_partial[7:0];
        o_res.green = r_partial[15:8];
        o_res.red   = (r_bpos == 2'd2) ? i_byte : r_partial[23:16];
        o_res.alpha = (r_bpos == 2'd2) ? ALPHA_OPAQUE : i_byte;
        o_res.repeat_res = 8'd1;
        o_res.last_pixel = 1'b0;
        o_res.overrun    = 1'b0;

        if (!r_in_body) begin
            // header byte; an empty image counter starts a new image
            if (r_ipl == '0) begin
                n_ipl = (r_pixel_total == '0) ? COUNT_W'(1) : r_pixel_total;
            end
            n_ppl     = (i_byte & HDR_COUNT_MASK) + 1'b1;
            n_run     = (i_byte & HDR_RUN_MASK) != '0;
            n_bpos    = 2'd0;
            n_partial = '0;
            n_discard = 1'b0;
            n_in_body = 1'b1;
        end else if (r_bpos < lastpos) begin
            case (r_bpos)
                2'd0:    n_partial[7:0]   = i_byte;
                2'd1:    n_partial[15:8]  = i_byte;
                default: n_partial[23:16] = i_byte;
            endcase
            n_bpos = r_bpos + 1'b1;
        end else begin
            n_bpos    = 2'd0;
            n_partial = '0;
            if (r_discard) begin
                // drop the leftover pixels of a raw packet past image end
                n_ppl = ppl_dec;
                if (ppl_dec == '0) begin
                    n_discard = 1'b0;
                    n_in_body = 1'b0;
                end
            end else if (r_run) begin
                o_res_valid      = 1'b1;
                o_res.repeat_res = run_rep;
                o_res.overrun    = ppl_wide > r_ipl;
                n_ipl            = r_ipl - {{(COUNT_W-PPL_W){1'b0}}, run_rep};
                o_res.last_pixel = n_ipl == '0;
                n_ppl            = '0;
                n_in_body        = 1'b0;
            end else begin
                o_res_valid      = 1'b1;
                n_ppl            = ppl_dec;
                n_ipl            = ipl_dec;
                o_res.last_pixel = ipl_dec == '0;
                o_res.overrun    = (ipl_dec == '0) && (ppl_dec != '0);
                if (ppl_dec == '0) begin
                    n_in_body = 1'b0;
                end else if (ipl_dec == '0) begin
                    n_discard = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body <= 1'b0;
            r_run     <= 1'b0;
            r_ppl     <= '0;
            r_bpos    <= 2'd0;
            r_partial <= '0;
            r_ipl     <= '0;
            r_discard <= 1'b0;
        end else if (i_advance) begin
            r_in_body <= n_in_body;
            r_run     <= n_run;
            r_ppl     <= n_ppl;
            r_bpos    <= n_bpos;
            r_partial <= n_partial;
            r_ipl     <= n_ipl;
            r_discard <= n_discard;
        end
    end

endmodule

/* src/trle_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_out_buf
// Two-entry result buffer; decouples the decoder from output stalls.
// ----------------------------------------------------------------------------
module trle_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  trle_pkg::t_pixel_res i_res,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_pop,
    output trle_pkg::t_pixel_res o_res
);
    import trle_pkg::*;

    t_pixel_res r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop_ok;

    assign o_space = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_res   = r_slot[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/tga_rle_pixel_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decodes run-length coded true-colour image bytes into pixels with repeats.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one coded byte per item in s_axis_tdata. Master stream: one
//   pixel per item with its repeat count; tlast marks the pixel that ends the
//   image and tuser flags a packet that asked for more pixels than remained.
//   Headers and colour bytes that do not complete a pixel give no result.
//   Configuration: write register 0 (four-byte pixels) or 1 (pixel total)
//   through i_cfg_valid / i_cfg_index / i_cfg_data while the stream is idle;
//   o_cfg_ready is always high.
//   Latency: a completing byte passes through the input register, then is
//   decoded into the result buffer, where it shows as a result.
//   Throughput: one byte per cycle, held only by the two-entry result
//   buffer filling up when the receiver stalls; s_axis_tready then drops
//   while a byte waits in the input register, and nothing is lost.
//   Reset: empties both registers, returns to header state with no image
//   in progress, and sets 32-bit pixels and a pixel total of one.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // data_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // blue [7:0], green [15:8], red [23:16], alpha [31:24], repeat_res [39:32]
    output logic [trle_pkg::RES_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,  // last_pixel
    output logic                              m_axis_tuser,  // overrun
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [trle_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [trle_pkg::COUNT_W-1:0]      i_cfg_data
);
    import trle_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              advance;
    logic              buf_space;
    logic              res_valid;
    t_pixel_res        res;
    t_pixel_res        out_res;

    assign advance       = r_in_valid && buf_space;
    assign s_axis_tready = !r_in_valid || buf_space;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    trle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    trle_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance && res_valid),
        .i_res   (res),
        .o_space (buf_space),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {out_res.repeat_res, out_res.alpha, out_res.red,
                           out_res.green, out_res.blue};
    assign m_axis_tlast = out_res.last_pixel;
    assign m_axis_tuser = out_res.overrun;

endmodule

/* src/trle_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trle_checker
// Port-level checks of the pixel decoder, bound to the top level.
// ----------------------------------------------------------------------------
module trle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // an overrun always ends the image
    a_overrun_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("overrun flagged on a pixel that does not end the image");

    // every pixel covers at least one image position
    a_repeat_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:32] != 8'd0)
        else $error("pixel with zero repeat count");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind tga_rle_pixel_decoder trle_checker u_trle_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length coded pixel decoder. Coded bytes go
// in on the slave stream while a tracker class mirrors the decode state and
// queues the pixels each byte should produce. Every pixel on the master
// stream is compared field by field against the oldest queued pixel. Both
// streams idle at random outside the calm phases. The register settings change between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import trle_pkg::*;

    localparam int LATENCY_PAD = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_GOAL   = 450;

    // Mirrors the decoder state and holds the pixels still owed by the block.
    class rle_pixel_tracker;
        bit          four_byte;
        logic [31:0] pixel_total;
        bit          in_body;
        bit          run_pkt;
        bit          discarding;
        logic [7:0]  pkt_left;
        logic [1:0]  byte_pos;
        logic [23:0] partial;
        logic [31:0] img_left;
        t_pixel_res  pixels_due[$];
        int          mismatches;
        int          pixels_seen;

        function new();
            four_byte   = 1'b1;
            pixel_total = 32'd1;
            in_body     = 1'b0;
            run_pkt     = 1'b0;
            discarding  = 1'b0;
            pkt_left    = '0;
            byte_pos    = '0;
            partial     = '0;
            img_left    = '0;
            mismatches  = 0;
            pixels_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_FOUR_BYTE)
                four_byte = data[0];
            else if (idx == CFG_PIXEL_TOTAL)
                pixel_total = data;
        endfunction

        function void take_byte(logic [7:0] b);
            t_pixel_res px;
            logic [1:0] last_pos;
            logic [7:0] rep;
            bit         ovr;
            last_pos = four_byte ? 2'd3 : 2'd2;
            if (!in_body) begin
                // a header with no image in progress opens a new image
                if (img_left == 0)
                    img_left = (pixel_total == 0) ? 32'd1 : pixel_total;
                pkt_left   = (b & HDR_COUNT_MASK) + 8'd1;
                run_pkt    = (b & HDR_RUN_MASK) != 0;
                byte_pos   = '0;
                partial    = '0;
                discarding = 1'b0;
                in_body    = 1'b1;
                return;
            end
            if (byte_pos < last_pos) begin
                partial[8*byte_pos +: 8] = b;
                byte_pos++;
                return;
            end
            px.blue  = partial[7:0];
            px.green = partial[15:8];
            if (byte_pos == 2'd2) begin
                px.red   = b;
                px.alpha = ALPHA_OPAQUE;
            end else begin
                // fourth byte completes the pixel even after a switch to 3-byte mode
                px.red   = partial[23:16];
                px.alpha = b;
            end
            byte_pos = '0;
            partial  = '0;
            if (discarding) begin
                if (pkt_left != 0)
                    pkt_left--;
                if (pkt_left == 0) begin
                    discarding = 1'b0;
                    in_body    = 1'b0;
                end
                return;
            end
            if (run_pkt) begin
                rep      = (pkt_left < img_left) ? pkt_left : img_left[7:0];
                ovr      = pkt_left > img_left;
                img_left = img_left - rep;
                pkt_left = '0;
                in_body  = 1'b0;
            end else begin
                rep = 8'd1;
                if (pkt_left != 0)
                    pkt_left--;
                if (img_left != 0)
                    img_left--;
                ovr = (img_left == 0) && (pkt_left != 0);
                if (pkt_left == 0)
                    in_body = 1'b0;
                else if (img_left == 0)
                    discarding = 1'b1;
            end
            px.repeat_res = rep;
            px.last_pixel = (img_left == 0);
            px.overrun    = ovr;
            pixels_due.push_back(px);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_pixel(logic [RES_DATA_W-1:0] data, logic last, logic ovr);
            t_pixel_res want;
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel, expected none actual %h last %b ovr %b",
                         $time, data, last, ovr);
                mismatches++;
                return;
            end
            want = pixels_due.pop_front();
            pixels_seen++;
            check_field("blue", want.blue, data[7:0]);
            check_field("green", want.green, data[15:8]);
            check_field("red", want.red, data[23:16]);
            check_field("alpha", want.alpha, data[31:24]);
            check_field("repeat", want.repeat_res, data[39:32]);
            check_field("last", {7'd0, want.last_pixel}, {7'd0, last});
            check_field("overrun", {7'd0, want.overrun}, {7'd0, ovr});
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [RES_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [COUNT_W-1:0]     i_cfg_data;

    rle_pixel_tracker tracker;
    bit               calm;
    int               bytes_sent;
    int               phase;
    int               idle_cycles = 0;

    tga_rle_pixel_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // pixel sink: check on handshake, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.compare_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        m_axis_tready <= calm || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid stays high across back-to-back items; drop it only for a gap
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(99) < 4) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_pixel();
        repeat (tracker.four_byte ? 4 : 3) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_packet(input bit run, input int count);
        send_byte((run ? HDR_RUN_MASK : 8'd0) | (8'(count - 1) & HDR_COUNT_MASK));
        repeat (run ? 1 : count) send_pixel();
    endtask

    // hold until every owed pixel has come out and the pipeline is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pixels_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic configure(input bit four, input logic [31:0] total);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FOUR_BYTE;
        i_cfg_data  <= {31'd0, four};
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(CFG_FOUR_BYTE, {31'd0, four});
        i_cfg_index <= CFG_PIXEL_TOTAL;
        i_cfg_data  <= total;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(CFG_PIXEL_TOTAL, total);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_packet();
        int  sel;
        int  count;
        bit  run;
        sel = $urandom_range(99);
        run = 1'($urandom_range(1));
        if (sel < 12) begin
            // noise: loose bytes that knock the stream out of step
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end else begin
            if (run)
                count = $urandom_range(1) ? $urandom_range(1, 128) : $urandom_range(1, 6);
            else if ($urandom_range(24) == 0)
                count = 128;
            else
                count = $urandom_range(1, 6);
            send_packet(run, count);
        end
    endtask

    initial begin
        logic [31:0] total;
        tracker       = new();
        calm          = 1'b0;
        bytes_sent    = 0;
        phase         = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= CFG_FOUR_BYTE;
        i_cfg_data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero total acts as one; longest run clamps to it
        configure(1'b1, 32'd0);
        send_byte(HDR_RUN_MASK | HDR_COUNT_MASK);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'hff);
        drain();

        // 24-bit raw packets, the second running past the image end
        configure(1'b0, 32'd3);
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'hff);
        send_packet(1'b0, 4);
        send_packet(1'b1, 2);
        drain();

        // switch to 3-byte mode with a pixel at its fourth byte
        configure(1'b1, 32'd1);
        send_byte(HDR_RUN_MASK);
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
        drain();
        configure(1'b0, 32'd1);
        send_byte(8'($urandom_range(255)));
        drain();

        while (bytes_sent < BYTE_GOAL) begin
            int budget;
            int pick;
            pick = $urandom_range(9);
            if (pick == 0)
                total = 32'd0;
            else if (pick == 1)
                total = 32'd1;
            else
                total = $urandom_range(2, 40);
            calm = (phase == 4 || phase == 5);
            configure(1'($urandom_range(1)), total);
            budget = bytes_sent + $urandom_range(30, 70);
            while (bytes_sent < budget) random_packet();
            drain();
            phase++;
        end

        // large pixel total of 0xfffe0001, near the top of the 32-bit range
        calm = 1'b0;
        configure(1'($urandom_range(1)), 32'hfffe_0001);
        repeat (4) random_packet();
        drain();

        $display("Sent %0d coded bytes in %0d random phases; %0d pixels checked.",
                 bytes_sent, phase, tracker.pixels_seen);
        $display("Covered run and raw packets, both pixel sizes, clamped runs and dropped tails.");
        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
